### src/assert_macros.svh
// assertion macros shared by the monitor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// concurrent assertion on the block clock, masked during reset
`define ASSERT_AT(lbl, prop, msg) \
  `ASSERT_CLKD(lbl, clk, rst, prop, msg)

`endif

### src/wtrlm_pkg.sv
// shared types and constants of the wakeup-to-run latency monitor
package wtrlm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32768;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned TASK_ID_W = 15;
  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned EV_COUNT  = 6;
  localparam int unsigned CFG_W     = 1;

  // stamp table entry: valid mark above the 64-bit stamp
  localparam int unsigned ENTRY_W = STAMP_W + 1;

  // stream widths
  localparam int unsigned S_DATA_W = ((TASK_ID_W + STAMP_W + 7) / 8) * 8;
  localparam int unsigned S_USER_W = OP_W + 1;
  localparam int unsigned M_DATA_W = (EV_COUNT + 4) * CNT_W;
  localparam int unsigned M_USER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WAKEUP     = 3'd0,
    OP_WAKEUP_NEW = 3'd1,
    OP_SWITCH     = 3'd2,
    OP_EXIT       = 3'd3,
    OP_PAGE_ALLOC = 3'd4,
    OP_PAGE_FREE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ACCUM,
    S_POST
  } state_t;

endpackage

### src/wtrlm_stamp_ram.sv
// wakeup stamp table: simple dual-port ram with registered read
module wtrlm_stamp_ram #(
  parameter int unsigned DEPTH = wtrlm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [wtrlm_pkg::ENTRY_W-1:0]    wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [wtrlm_pkg::ENTRY_W-1:0]    rdata
);
  import wtrlm_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/wakeup_to_run_latency_monitor_top.sv
// top level of the wakeup-to-run latency monitor
//
// Takes one scheduler or memory event per transaction and returns one result
// per event with all event counters and latency statistics after it. An event
// passes through accept with the stamp table read, then look-up and
// write-back; a switch-in that yields a delay sample then passes through the
// accumulate state, folding the delay into sum, count, last and peak. The
// stamp table is a single ram with registered read; a result waits in the
// output register while the next event is taken in. After reset a clearing
// pass sweeps the table one entry per cycle, during which no event is
// accepted; filter writes are taken at any time.
`include "assert_macros.svh"

module wakeup_to_run_latency_monitor_top #(
  parameter int unsigned TABLE_DEPTH = wtrlm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // task_id, now_ns, zero pad
  input  logic [wtrlm_pkg::S_DATA_W-1:0]  s_tdata,
  // opcode, in_namespace
  input  logic [wtrlm_pkg::S_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // wakeup_total, wakeup_new_total, switch_total, exit_total, page_alloc_total,
  // page_free_total, latency_sum, latency_samples, latency_recent, latency_peak
  output logic [wtrlm_pkg::M_DATA_W-1:0]  m_tdata,
  // accepted, latency_measured
  output logic [wtrlm_pkg::M_USER_W-1:0]  m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  // namespace_filter_on
  input  logic [wtrlm_pkg::CFG_W-1:0]     cfg_data
);
  import wtrlm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = ((AW > TASK_ID_W) ? AW : TASK_ID_W) + 1;
  localparam logic [IW-1:0] DEPTH_X  = IW'(TABLE_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  // input field unpack
  logic [OP_W-1:0]      in_op;
  logic [TASK_ID_W-1:0] in_tid;
  logic [STAMP_W-1:0]   in_now;
  logic                 in_ns;
  logic [IW-1:0]        in_tid_x;
  logic                 in_acc;
  logic                 in_in_table;

  assign in_op    = s_tuser[OP_W-1:0];
  assign in_ns    = s_tuser[OP_W];
  assign in_tid   = s_tdata[TASK_ID_W-1:0];
  assign in_now   = s_tdata[TASK_ID_W +: STAMP_W];
  assign in_tid_x = IW'(in_tid);

  // configuration register
  logic filter_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_on <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      filter_on <= cfg_data[0];
    end
  end

  // event filter and table range check at accept
  assign in_acc      = (in_op < OP_W'(EV_COUNT)) && !(filter_on && !in_ns);
  assign in_in_table = in_tid_x < DEPTH_X;

  // control state
  state_t state, state_next;
  logic [AW-1:0] clr_addr;

  // event held during processing
  op_t                item_op;
  logic               item_acc;
  logic               item_in_table;
  logic [AW-1:0]      item_addr;
  logic [STAMP_W-1:0] item_now;
  logic [STAMP_W-1:0] delta;
  logic               meas;

  // stamp ram signals
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               rd_valid;
  logic [STAMP_W-1:0] rd_stamp;

  assign rd_valid = mem_rdata[STAMP_W];
  assign rd_stamp = mem_rdata[STAMP_W-1:0];

  wtrlm_stamp_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_tid_x[AW-1:0]),
    .rdata (mem_rdata)
  );

  // look-up decode: one wide subtract gives both delay and ordering
  logic [STAMP_W:0] diff;
  logic             advanced;
  logic             wake_hit;
  logic             switch_hit;
  logic             meas_now;

  assign diff       = {1'b0, item_now} - {1'b0, rd_stamp};
  assign advanced   = !diff[STAMP_W] && (diff[STAMP_W-1:0] != '0);
  assign wake_hit   = item_acc && item_in_table &&
                      (item_op == OP_WAKEUP || item_op == OP_WAKEUP_NEW);
  assign switch_hit = item_acc && item_in_table && (item_op == OP_SWITCH) && rd_valid;
  assign meas_now   = (state == S_LOOK) ? (switch_hit && advanced) : meas;

  // sequencer
  logic out_free;
  logic out_load;
  logic cnt_commit;
  logic stat_commit;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = item_addr;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    cnt_commit  = 1'b0;
    stat_commit = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        mem_re   = s_tvalid;
        if (s_tvalid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cnt_commit = item_acc;
        // wakeup stores its stamp, a matching switch-in retires the entry
        if (wake_hit) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, item_now};
        end else if (switch_hit) begin
          mem_we = 1'b1;
        end
        if (switch_hit && advanced) begin
          state_next = S_ACCUM;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_POST;
        end
      end
      S_ACCUM: begin
        stat_commit = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // capture of the accepted event
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op       <= op_t'(in_op);
      item_acc      <= in_acc;
      item_in_table <= in_in_table;
      item_addr     <= in_tid_x[AW-1:0];
      item_now      <= in_now;
    end
  end

  // delay sample taken at look-up
  always_ff @(posedge clk) begin
    if (rst) begin
      meas <= 1'b0;
    end else if (state == S_LOOK) begin
      meas <= switch_hit && advanced;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      delta <= diff[STAMP_W-1:0];
    end
  end

  // event counters
  logic [CNT_W-1:0] ev_cnt      [EV_COUNT];
  logic [CNT_W-1:0] ev_cnt_next [EV_COUNT];

  always_comb begin
    for (int k = 0; k < EV_COUNT; k++) begin
      ev_cnt_next[k] = (cnt_commit && item_op == op_t'(OP_W'(k))) ?
                       ev_cnt[k] + CNT_W'(1) : ev_cnt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < EV_COUNT; k++) begin
        ev_cnt[k] <= '0;
      end
    end else begin
      for (int k = 0; k < EV_COUNT; k++) begin
        ev_cnt[k] <= ev_cnt_next[k];
      end
    end
  end

  // latency statistics
  logic [CNT_W-1:0] lat_sum,     lat_sum_next;
  logic [CNT_W-1:0] lat_samples, lat_samples_next;
  logic [CNT_W-1:0] lat_recent,  lat_recent_next;
  logic [CNT_W-1:0] lat_peak,    lat_peak_next;

  assign lat_sum_next     = stat_commit ? lat_sum + delta : lat_sum;
  assign lat_samples_next = stat_commit ? lat_samples + CNT_W'(1) : lat_samples;
  assign lat_recent_next  = stat_commit ? delta : lat_recent;
  assign lat_peak_next    = (stat_commit && delta > lat_peak) ? delta : lat_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_sum     <= '0;
      lat_samples <= '0;
      lat_recent  <= '0;
      lat_peak    <= '0;
    end else begin
      lat_sum     <= lat_sum_next;
      lat_samples <= lat_samples_next;
      lat_recent  <= lat_recent_next;
      lat_peak    <= lat_peak_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {lat_peak_next, lat_recent_next, lat_samples_next, lat_sum_next,
                  ev_cnt_next[5], ev_cnt_next[4], ev_cnt_next[3],
                  ev_cnt_next[2], ev_cnt_next[1], ev_cnt_next[0]};
      m_tuser <= {meas_now, item_acc};
    end
  end

  // checks
  `ASSERT_AT(a_accept_to_look, (s_tvalid && s_tready) |=> (state == S_LOOK),
             "accepted transaction did not move to look-up")
  `ASSERT_AT(a_measured_is_accepted, (m_tvalid && m_tuser[1]) |-> m_tuser[0],
             "delay sample reported on a dropped event")
  `ASSERT_AT(a_peak_covers_recent,
             m_tvalid |-> (m_tdata[9*CNT_W +: CNT_W] >= m_tdata[8*CNT_W +: CNT_W]),
             "peak latency below most recent latency")
  `ASSERT_AT(a_load_when_free, out_load |-> (!m_tvalid || m_tready),
             "pending result overwritten")

endmodule
